[design/ppr_pkg.sv]
// ----------------------------------------------------------------------------
// ppr_pkg: shared types for the pending publish retry table
// Command, result and table entry layouts, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned ResW       = 5;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DRAIN = 2'd1,
    OP_CLEAN = 2'd2,
    OP_TICK  = 2'd3
  } opcode_e;

  typedef enum logic {
    REG_DUE    = 1'b0,
    REG_ENABLE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] msg_id;
    logic [31:0] topic_handle;
    logic [31:0] data_handle;
    logic [15:0] payload_length;
    logic [1:0]  qos_level;
    logic        retain_flag;
    logic [31:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic        accepted;
    logic [4:0]  entry_count;
    logic        repub_valid;
    logic [15:0] repub_msg_id;
    logic [31:0] repub_topic_handle;
    logic [31:0] repub_data_handle;
    logic [15:0] repub_length;
    logic [1:0]  repub_qos;
    logic        repub_retain;
    logic [15:0] repub_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] topic;
    logic [31:0] data;
    logic [15:0] length;
    logic [1:0]  qos;
    logic        retain;
    logic [15:0] pub_count;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic cand;
  } match_t;

endpackage

[design/ppr_ram.sv]
// ----------------------------------------------------------------------------
// ppr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ppr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/ppr_match.sv]
// ----------------------------------------------------------------------------
// ppr_match: shared entry compare unit
// Checks one entry per cycle for an id hit and for being the next due entry.
// ----------------------------------------------------------------------------
module ppr_match (
  input  ppr_pkg::entry_t ent_i,
  input  logic            ent_valid_i,
  input  logic [15:0]     msg_id_i,
  input  logic [31:0]     now_i,
  input  logic [31:0]     due_i,
  input  logic            have_floor_i,
  input  logic [15:0]     floor_i,
  input  logic            best_found_i,
  input  logic [15:0]     best_id_i,
  output ppr_pkg::match_t match_o
);
  import ppr_pkg::*;

  logic [31:0] age;
  logic        is_due;
  logic        above_floor;
  logic        better;

  always_comb begin
    age           = now_i - ent_i.stamp;
    is_due        = age > due_i;
    above_floor   = !have_floor_i || (ent_i.id > floor_i);
    better        = !best_found_i || (ent_i.id < best_id_i);
    match_o.hit   = ent_valid_i && (ent_i.id == msg_id_i);
    match_o.cand  = ent_valid_i && is_due && above_floor && better;
  end

endmodule

[design/pending_publish_retry_table.sv]
// ----------------------------------------------------------------------------
// pending_publish_retry_table: retransmit table for unacknowledged publishes
// Add, drain, clean and tick scan over a table of CAPACITY entries.
// ----------------------------------------------------------------------------
// Add and drain scan the whole table before the result; clean does not scan.
// A tick scan walks the whole table once per emitted entry, through the shared
// compare unit and table RAM port, for up to 16 entries. One command at a
// time; busy holds off the next. Results are single-cycle strobes; the
// receiver cannot stall.
// Reset empties the table and loads due_duration 20, repub_enable 0.
module pending_publish_retry_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  ppr_pkg::cmd_t         cmd_i,
  output logic                  strobe_o,
  output ppr_pkg::res_t         res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import ppr_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;

  logic [31:0]   due_q;
  logic          en_q;
  cmd_t          cmd_q;
  logic [AW-1:0] ptr_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_slot_q;
  logic [CAPACITY-1:0] valid_q;
  logic [CW-1:0] count_q, count_d;
  logic          hit_q;
  logic [AW-1:0] hit_slot_q;
  logic          free_found_q;
  logic [AW-1:0] free_slot_q;
  logic          best_found_q;
  entry_t        best_q;
  logic [AW-1:0] best_slot_q;
  logic          have_floor_q;
  logic [15:0]   floor_q;
  logic          pend_q;
  entry_t        pend_ent_q;
  logic [ResW-1:0] nres_q;
  logic          strobe_q;
  res_t          res_q;

  logic          accept;
  logic          cfg_wr;
  logic          new_pass;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  entry_t        rdata;
  logic          emit;
  res_t          emit_res;
  logic          add_ok;
  logic          drain_ok;
  match_t        match;

  assign accept = start && !busy;
  assign busy   = state_q != S_IDLE;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (reg_idx_e'(paddr[2]) == REG_ENABLE) ? {31'd0, en_q} : due_q;

  ppr_ram #(
    .Width ($bits(entry_t)),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  ppr_match u_match (
    .ent_i        (rdata),
    .ent_valid_i  (rd_vld_q && valid_q[rd_slot_q]),
    .msg_id_i     (cmd_q.msg_id),
    .now_i        (cmd_q.now_time),
    .due_i        (due_q),
    .have_floor_i (have_floor_q),
    .floor_i      (floor_q),
    .best_found_i (best_found_q),
    .best_id_i    (best_q.id),
    .match_o      (match)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_e'(cmd_i.opcode) == OP_CLEAN ||
              (opcode_e'(cmd_i.opcode) == OP_TICK && !en_q)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (ptr_q == AW'(CAPACITY - 1)) begin
          state_d = S_LAST;
        end
      end
      S_LAST:  state_d = S_DONE;
      S_DONE: begin
        if (opcode_e'(cmd_q.opcode) == OP_TICK && best_found_q) begin
          state_d = (nres_q == ResW'(MaxResults - 1)) ? S_FLUSH : S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FLUSH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    we       = 1'b0;
    waddr    = best_slot_q;
    wdata    = best_q;
    emit     = 1'b0;
    emit_res = '0;
    add_ok   = !hit_q && free_found_q;
    drain_ok = hit_q;
    count_d  = count_q;
    new_pass = (state_q == S_IDLE && state_d == S_SCAN) ||
               (state_q == S_DONE && state_d == S_SCAN);
    case (state_q)
      S_DONE: begin
        case (opcode_e'(cmd_q.opcode))
          OP_ADD: begin
            if (add_ok) begin
              we      = 1'b1;
              waddr   = free_slot_q;
              wdata   = '{id: cmd_q.msg_id, topic: cmd_q.topic_handle,
                          data: cmd_q.data_handle, length: cmd_q.payload_length,
                          qos: cmd_q.qos_level, retain: cmd_q.retain_flag,
                          pub_count: 16'd1, stamp: cmd_q.now_time};
              count_d = count_q + CW'(1);
            end
            emit              = 1'b1;
            emit_res.accepted = add_ok;
            emit_res.last     = 1'b1;
          end
          OP_DRAIN: begin
            if (drain_ok) begin
              count_d = count_q - CW'(1);
            end
            emit              = 1'b1;
            emit_res.accepted = drain_ok;
            emit_res.last     = 1'b1;
          end
          OP_CLEAN: begin
            count_d       = '0;
            emit          = 1'b1;
            emit_res.last = 1'b1;
          end
          OP_TICK: begin
            if (best_found_q) begin
              // restamp and bump the entry just picked
              we              = 1'b1;
              wdata.stamp     = cmd_q.now_time;
              wdata.pub_count = (best_q.pub_count == 16'hFFFF) ?
                                best_q.pub_count : best_q.pub_count + 16'd1;
              emit            = pend_q;
            end else begin
              emit          = 1'b1;
              emit_res.last = 1'b1;
            end
            if (pend_q) begin
              emit_res.repub_valid        = 1'b1;
              emit_res.repub_msg_id       = pend_ent_q.id;
              emit_res.repub_topic_handle = pend_ent_q.topic;
              emit_res.repub_data_handle  = pend_ent_q.data;
              emit_res.repub_length       = pend_ent_q.length;
              emit_res.repub_qos          = pend_ent_q.qos;
              emit_res.repub_retain       = pend_ent_q.retain;
              emit_res.repub_count        = pend_ent_q.pub_count;
            end
          end
          default: ;
        endcase
      end
      S_FLUSH: begin
        emit                        = 1'b1;
        emit_res.last               = 1'b1;
        emit_res.repub_valid        = 1'b1;
        emit_res.repub_msg_id       = pend_ent_q.id;
        emit_res.repub_topic_handle = pend_ent_q.topic;
        emit_res.repub_data_handle  = pend_ent_q.data;
        emit_res.repub_length       = pend_ent_q.length;
        emit_res.repub_qos          = pend_ent_q.qos;
        emit_res.repub_retain       = pend_ent_q.retain;
        emit_res.repub_count        = pend_ent_q.pub_count;
      end
      default: ;
    endcase
    emit_res.entry_count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      due_q        <= 32'd20;
      en_q         <= 1'b0;
      valid_q      <= '0;
      count_q      <= '0;
      rd_vld_q     <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      have_floor_q <= 1'b0;
      pend_q       <= 1'b0;
      nres_q       <= '0;
      ptr_q        <= '0;
      strobe_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= emit;
      if (cfg_wr) begin
        case (reg_idx_e'(paddr[2]))
          REG_DUE:    due_q <= pwdata;
          REG_ENABLE: en_q  <= pwdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        have_floor_q <= 1'b0;
        pend_q       <= 1'b0;
        nres_q       <= '0;
      end
      if (accept || new_pass) begin
        best_found_q <= 1'b0;
      end
      if (new_pass) begin
        ptr_q        <= '0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end
      // issue one table read a cycle, compare it the cycle after
      rd_vld_q <= state_q == S_SCAN;
      if (state_q == S_SCAN) begin
        rd_slot_q <= ptr_q;
        ptr_q     <= ptr_q + AW'(1);
        if (!valid_q[ptr_q] && !free_found_q) begin
          free_found_q <= 1'b1;
          free_slot_q  <= ptr_q;
        end
      end
      if (match.hit) begin
        hit_q      <= 1'b1;
        hit_slot_q <= rd_slot_q;
      end
      if (match.cand && opcode_e'(cmd_q.opcode) == OP_TICK) begin
        best_found_q <= 1'b1;
        best_q       <= rdata;
        best_slot_q  <= rd_slot_q;
      end
      if (state_q == S_DONE) begin
        case (opcode_e'(cmd_q.opcode))
          OP_ADD:   if (add_ok) valid_q[free_slot_q] <= 1'b1;
          OP_DRAIN: if (drain_ok) valid_q[hit_slot_q] <= 1'b0;
          OP_CLEAN: valid_q <= '0;
          OP_TICK: begin
            if (best_found_q) begin
              pend_q       <= 1'b1;
              pend_ent_q   <= best_q;
              floor_q      <= best_q.id;
              have_floor_q <= 1'b1;
              nres_q       <= nres_q + ResW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept) begin
      cmd_q <= cmd_i;
    end
    res_q <= emit_res;
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

  // a result without an entry always closes its command
  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !res_o.repub_valid |-> res_o.last)
    else $error("plain result without last");

  a_repub_not_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && res_o.repub_valid |-> !res_o.accepted)
    else $error("republish result marked accepted");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("command accepted but not busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for pending_publish_retry_table
// Drives add, drain, clean and tick commands with random gaps and checks
// every result strobe against an in-bench model of the retransmit table.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppr_pkg::*;

  localparam int unsigned Depth    = 16;
  localparam int unsigned DrainLat = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd_i = '0;
  logic        strobe_o;
  res_t        res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pending_publish_retry_table #(.CAPACITY(Depth)) u_top (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .strobe_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  // table model
  logic        slot_used[Depth];
  entry_t      slot[Depth];
  logic [31:0] due_cfg = 32'd20;
  logic        enable_cfg = 1'b0;

  cmd_t cmd_q[$];
  res_t pending_res_q[$];
  cmd_t cur_cmd;
  int   gap_left = 0;
  int   n_cmds = 0;
  int   n_results = 0;
  int   n_repubs = 0;
  int   n_errors = 0;
  logic [31:0] clock_s = 32'd0;

  function automatic int held();
    int n;
    n = 0;
    for (int i = 0; i < Depth; i++) if (slot_used[i]) n++;
    return n;
  endfunction

  function automatic int find_slot(logic [15:0] id);
    for (int i = 0; i < Depth; i++) if (slot_used[i] && slot[i].id == id) return i;
    return -1;
  endfunction

  function automatic res_t plain_res(logic acc);
    res_t r;
    r = '0;
    r.accepted    = acc;
    r.entry_count = 5'(held());
    r.last        = 1'b1;
    return r;
  endfunction

  task automatic predict_table(cmd_t c);
    int   s, best, n;
    logic acc;
    logic have_floor;
    logic [15:0] floor_id;
    res_t r;
    acc = 1'b0;
    n = 0;
    case (opcode_e'(c.opcode))
      OP_ADD: begin
        if (find_slot(c.msg_id) < 0) begin
          for (int i = 0; i < Depth; i++) begin
            if (!slot_used[i] && !acc) begin
              slot_used[i] = 1'b1;
              slot[i] = '{id: c.msg_id, topic: c.topic_handle, data: c.data_handle,
                          length: c.payload_length, qos: c.qos_level,
                          retain: c.retain_flag, pub_count: 16'd1, stamp: c.now_time};
              acc = 1'b1;
            end
          end
        end
        pending_res_q.push_back(plain_res(acc));
      end
      OP_DRAIN: begin
        s = find_slot(c.msg_id);
        if (s >= 0) slot_used[s] = 1'b0;
        pending_res_q.push_back(plain_res(s >= 0));
      end
      OP_CLEAN: begin
        for (int i = 0; i < Depth; i++) slot_used[i] = 1'b0;
        pending_res_q.push_back(plain_res(1'b0));
      end
      default: begin
        have_floor = 1'b0;
        floor_id = '0;
        while (enable_cfg && n < MaxResults) begin
          best = -1;
          for (int i = 0; i < Depth; i++) begin
            if (slot_used[i] && !(have_floor && slot[i].id <= floor_id) &&
                (c.now_time - slot[i].stamp) > due_cfg &&
                (best < 0 || slot[i].id < slot[best].id))
              best = i;
          end
          if (best < 0) break;
          r = plain_res(1'b0);
          r.repub_valid        = 1'b1;
          r.repub_msg_id       = slot[best].id;
          r.repub_topic_handle = slot[best].topic;
          r.repub_data_handle  = slot[best].data;
          r.repub_length       = slot[best].length;
          r.repub_qos          = slot[best].qos;
          r.repub_retain       = slot[best].retain;
          r.repub_count        = slot[best].pub_count;
          r.last               = 1'b0;
          pending_res_q.push_back(r);
          if (slot[best].pub_count != 16'hFFFF) slot[best].pub_count++;
          slot[best].stamp = c.now_time;
          floor_id = slot[best].id;
          have_floor = 1'b1;
          n++;
          n_repubs++;
        end
        if (n == 0) pending_res_q.push_back(plain_res(1'b0));
        else pending_res_q[$].last = 1'b1;
      end
    endcase
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_table(cur_cmd);
        n_cmds++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          cmd_i <= cur_cmd;
          start <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      n_results++;
      if (pending_res_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result %h", res_o);
      end else begin
        res_t want;
        want = pending_res_q.pop_front();
        if (res_o !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result mismatch\n  expected %p\n  actual   %p", want, res_o);
        end
      end
    end
  end

  function automatic cmd_t mk_cmd(opcode_e op, logic [15:0] id);
    cmd_t c;
    c.opcode         = op;
    c.msg_id         = id;
    c.topic_handle   = $urandom;
    c.data_handle    = $urandom;
    c.payload_length = 16'($urandom);
    c.qos_level      = 2'($urandom_range(0, 3));
    c.retain_flag    = 1'($urandom);
    c.now_time       = clock_s;
    return c;
  endfunction

  task automatic push(opcode_e op, logic [15:0] id);
    cmd_q.push_back(mk_cmd(op, id));
  endtask

  task automatic wait_idle();
    wait (cmd_q.size() == 0 && !start && pending_res_q.size() == 0);
    repeat (DrainLat) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_DUE) due_cfg = val;
    else enable_cfg = val[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(int n_items);
    int p;
    logic [15:0] id;
    for (int k = 0; k < n_items; k++) begin
      p = $urandom_range(99);
      if (p < 10) clock_s += $urandom;
      else clock_s += $urandom_range(0, 12);
      id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
      p = $urandom_range(99);
      if (p < 45) push(OP_ADD, id);
      else if (p < 68) push(OP_DRAIN, id);
      else if (p < 95) push(OP_TICK, id);
      else push(OP_CLEAN, id);
    end
  endtask

  initial begin
    cmd_t c;
    for (int i = 0; i < Depth; i++) slot_used[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset config, republish disabled
    clock_s = 32'hFFFF_FFF0;
    push(OP_TICK, 16'd0);
    c = mk_cmd(OP_ADD, 16'hFFFF);
    c.topic_handle = '1; c.data_handle = '1; c.payload_length = '1;
    c.qos_level = 2'd3; c.retain_flag = 1'b1;
    cmd_q.push_back(c);
    c = mk_cmd(OP_ADD, 16'd0);
    c.topic_handle = '0; c.data_handle = '0; c.payload_length = '0;
    c.qos_level = 2'd0; c.retain_flag = 1'b0;
    cmd_q.push_back(c);
    push(OP_ADD, 16'hFFFF);
    push(OP_DRAIN, 16'd77);
    push(OP_DRAIN, 16'd0);
    for (int i = 1; i <= 15; i++) push(OP_ADD, 16'(i * 997));
    push(OP_ADD, 16'd5);
    clock_s = 32'd100;
    push(OP_TICK, 16'd0);
    wait_idle();

    // enable, due zero: full table emits all sixteen across the time wrap
    reg_write(REG_ENABLE, 32'd1);
    reg_write(REG_DUE, 32'd0);
    push(OP_TICK, 16'd0);
    push(OP_TICK, 16'd0);
    clock_s += 1;
    push(OP_TICK, 16'd0);
    push(OP_CLEAN, 16'd0);
    push(OP_TICK, 16'd0);
    wait_idle();

    reg_write(REG_DUE, 32'd5);
    random_phase(45);
    wait_idle();
    reg_write(REG_DUE, 32'hFFFF_FFFF);
    random_phase(30);
    wait_idle();
    reg_write(REG_DUE, 32'd0);
    random_phase(40);
    wait_idle();
    reg_write(REG_ENABLE, 32'd0);
    reg_write(REG_DUE, 32'd20);
    random_phase(25);
    wait_idle();

    $display("Ran %0d commands, checked %0d results including %0d republished entries.",
             n_cmds, n_results, n_repubs);
    $display("Covered dedup, full table, drains, cleans, wraps and four timeout settings.");
    if (n_errors == 0) begin
      $display("pending_publish_retry_table test passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("pending_publish_retry_table test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("pending_publish_retry_table test failed");
    $finish;
  end

endmodule
